// ===== sv/qalu_pkg.sv =====
// shared types, constants and helper functions of the quaternion unit
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

  // fixed point format and datapath widths
  localparam int QALU_FRAC_BITS = 16;
  localparam int COMP_W         = 32;
  localparam int SUMSQ_W        = 65;
  localparam int ROOT_W         = 33;
  localparam int QUO_W          = 32;

  // latencies of the datapath units
  localparam int HAM_LAT  = 2;
  localparam int SQRT_LAT = 2 + ROOT_W;
  localparam int DIV_LAT  = 1 + QUO_W;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_SCALE     = 4'd2,
    OP_PRODUCT   = 4'd3,
    OP_CONJUGATE = 4'd4,
    OP_NORM      = 4'd5,
    OP_INVERSE   = 4'd6,
    OP_NORMALIZE = 4'd7,
    OP_ROTATE    = 4'd8
  } opcode_t;

  // index 0 is w, then x, y, z
  typedef logic [3:0][COMP_W-1:0] quat_t;

  typedef struct packed {
    quat_t r;
    logic  ov;
  } res_t;

  // operand index and negate flag of each Hamilton product term
  localparam logic [1:0] HAM_IDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  // saturate to signed 32 bits, top bit of the result is the overflow flag
  function automatic logic [COMP_W:0] sat_s32(input logic signed [65:0] v);
    logic [COMP_W:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[COMP_W-1:0]};
    end
    return res;
  endfunction

  // magnitude of a signed component as unsigned
  function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] v);
    return v[COMP_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/qalu_in_if.sv =====
// input channel interface: opcode, two quaternions and a scalar
`timescale 1ns / 1ps
`default_nettype none

interface qalu_in_if import qalu_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [3:0]               opcode;
  logic signed [COMP_W-1:0] q_w;
  logic signed [COMP_W-1:0] q_x;
  logic signed [COMP_W-1:0] q_y;
  logic signed [COMP_W-1:0] q_z;
  logic signed [COMP_W-1:0] p_w;
  logic signed [COMP_W-1:0] p_x;
  logic signed [COMP_W-1:0] p_y;
  logic signed [COMP_W-1:0] p_z;
  logic signed [COMP_W-1:0] scale;

  modport source (output valid, opcode, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z, scale,
                  input ready);
  modport sink (input valid, opcode, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z, scale,
                output ready);
endinterface

`default_nettype wire

// ===== sv/qalu_out_if.sv =====
// result channel interface: result quaternion and overflow flag
`timescale 1ns / 1ps
`default_nettype none

interface qalu_out_if import qalu_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] r_w;
  logic signed [COMP_W-1:0] r_x;
  logic signed [COMP_W-1:0] r_y;
  logic signed [COMP_W-1:0] r_z;
  logic                     overflow;

  modport source (output valid, r_w, r_x, r_y, r_z, overflow, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/quaternion_alu_top.sv =====
// quaternion arithmetic unit, Q16.16 by default, fully pipelined
//
//   channel  | dir | fields                                     | handshake
//   in_bus   | in  | opcode q_w q_x q_y q_z p_w p_x p_y p_z scale | valid/ready
//   out_bus  | out | r_w r_x r_y r_z overflow                   | valid/ready
//
// one item per cycle unless stalled; each item passes through the
// 35 stage square root (squares, sum, 33 root bits), the 33 stage divider lanes,
// the quotient merge register, the two stage second Hamilton product and the
// output buffer. a two entry output buffer takes finished results, so input
// keeps flowing while a result waits; the pipeline stalls only when the buffer
// is full and the last stage holds an item. synchronous active-low reset
// clears pipeline valids and the buffer count.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_alu_top import qalu_pkg::*; #(
  parameter int FRAC_BITS = QALU_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  qalu_in_if.sink    in_bus,
  qalu_out_if.source out_bus
);

  localparam int NUM_W    = COMP_W + 2 * FRAC_BITS;
  localparam int S_DIV_IN = SQRT_LAT;
  localparam int S_QI_IN  = S_DIV_IN + DIV_LAT;
  localparam int S_QI     = S_QI_IN + 1;
  localparam int S_OUT    = S_QI + HAM_LAT;

  logic             en;
  logic             push;
  logic             pop;
  logic [S_OUT:1]   v_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  res_t             ent0_r;
  res_t             ent1_r;

  quat_t            in_q;
  quat_t            in_p;
  quat_t            ham1_b;
  res_t             simple_nxt;
  res_t             simple_r;
  res_t             simple_o;
  res_t             t2;
  res_t             t_qi;
  res_t             t_o;
  logic [3:0]       op_div;
  logic [3:0]       op_qi;
  logic [3:0]       op_o;
  quat_t            q_div;
  quat_t            q_qi;
  logic [SUMSQ_W-1:0] sumsq;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  root_o;
  logic [SUMSQ_W-1:0] den;
  logic [NUM_W-1:0]   num [4];
  logic [QUO_W-1:0]   quo [4];
  logic [3:0]         big;
  res_t             qi_nxt;
  res_t             qi_r;
  res_t             qi_o;
  res_t             h2;
  res_t             fin;

  // pipeline advances unless the buffer is full and the last stage is busy
  assign en            = (cnt_r != 2'd2) || !v_r[S_OUT];
  assign in_bus.ready  = en;
  assign push          = en && v_r[S_OUT];
  assign pop           = out_bus.valid && out_bus.ready;

  assign in_q = {in_bus.q_z, in_bus.q_y, in_bus.q_x, in_bus.q_w};
  assign in_p = {in_bus.p_z, in_bus.p_y, in_bus.p_x, in_bus.p_w};

  // scale runs through the product lanes as q times (scale, 0, 0, 0)
  always_comb begin
    if (opcode_t'(in_bus.opcode) == OP_SCALE) begin
      ham1_b = {{(3*COMP_W){1'b0}}, in_bus.scale};
    end else begin
      ham1_b = in_p;
    end
  end

  // add, subtract and conjugate
  always_comb begin
    logic signed [COMP_W+1:0] a;
    logic signed [COMP_W+1:0] b;
    logic signed [COMP_W+1:0] s;
    logic [COMP_W:0]          sat;
    logic [3:0]               lane_ov;
    simple_nxt = '0;
    lane_ov = '0;
    for (int i = 0; i < 4; i++) begin
      a = (COMP_W+2)'($signed(in_q[i]));
      b = (COMP_W+2)'($signed(in_p[i]));
      case (opcode_t'(in_bus.opcode))
        OP_ADD:       s = a + b;
        OP_SUB:       s = a - b;
        OP_CONJUGATE: s = (i == 0) ? a : -a;
        default:      s = '0;
      endcase
      sat = sat_s32(66'(s));
      lane_ov[i] = sat[COMP_W];
      simple_nxt.r[i] = sat[COMP_W-1:0];
    end
    simple_nxt.ov = |lane_ov;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      simple_r <= simple_nxt;
    end
  end

  qalu_dly #(.WIDTH($bits(res_t)), .DEPTH(S_OUT - 1)) u_dly_simple (
    .clk(clk), .en(en), .d(simple_r), .q(simple_o)
  );

  // first Hamilton product: q * p, or q * scale
  qalu_ham #(.FRAC_BITS(FRAC_BITS)) u_ham1 (
    .clk(clk), .en(en), .a(in_q), .b(ham1_b), .y(t2)
  );

  qalu_dly #(.WIDTH($bits(res_t)), .DEPTH(S_QI - HAM_LAT)) u_dly_t1 (
    .clk(clk), .en(en), .d(t2), .q(t_qi)
  );

  qalu_dly #(.WIDTH($bits(res_t)), .DEPTH(S_OUT - S_QI)) u_dly_t2 (
    .clk(clk), .en(en), .d(t_qi), .q(t_o)
  );

  // opcode and q follow the divider path
  qalu_dly #(.WIDTH(4), .DEPTH(S_DIV_IN)) u_dly_op1 (
    .clk(clk), .en(en), .d(in_bus.opcode), .q(op_div)
  );

  qalu_dly #(.WIDTH(4), .DEPTH(S_QI_IN - S_DIV_IN)) u_dly_op2 (
    .clk(clk), .en(en), .d(op_div), .q(op_qi)
  );

  qalu_dly #(.WIDTH(4), .DEPTH(S_OUT - S_QI_IN)) u_dly_op3 (
    .clk(clk), .en(en), .d(op_qi), .q(op_o)
  );

  qalu_dly #(.WIDTH($bits(quat_t)), .DEPTH(S_DIV_IN)) u_dly_q1 (
    .clk(clk), .en(en), .d(in_q), .q(q_div)
  );

  qalu_dly #(.WIDTH($bits(quat_t)), .DEPTH(S_QI_IN - S_DIV_IN)) u_dly_q2 (
    .clk(clk), .en(en), .d(q_div), .q(q_qi)
  );

  // sum of squares and norm
  qalu_sqrt u_sqrt (
    .clk(clk), .en(en), .q(in_q), .sumsq(sumsq), .root(root)
  );

  qalu_dly #(.WIDTH(ROOT_W), .DEPTH(S_OUT - S_DIV_IN)) u_dly_root (
    .clk(clk), .en(en), .d(root), .q(root_o)
  );

  // divider operands: normalize divides by the norm, inverse and rotate by the sum of squares
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (opcode_t'(op_div) == OP_NORMALIZE) begin
        num[i] = NUM_W'(mag32(q_div[i])) << FRAC_BITS;
      end else begin
        num[i] = NUM_W'(mag32(q_div[i])) << (2 * FRAC_BITS);
      end
    end
    if (opcode_t'(op_div) == OP_NORMALIZE) begin
      den = SUMSQ_W'(root);
    end else begin
      den = sumsq;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    qalu_div #(.NUM_W(NUM_W)) u_div (
      .clk(clk), .en(en), .num(num[i]), .den(den), .quo(quo[i]), .big(big[i])
    );
  end

  // merge divider lanes: sign, saturate, zero quaternion passes through
  always_comb begin
    logic       inv_mode;
    logic       neg;
    logic [3:0] lane_ov;
    qi_nxt = '0;
    lane_ov = '0;
    inv_mode = (opcode_t'(op_qi) == OP_INVERSE) || (opcode_t'(op_qi) == OP_ROTATE);
    for (int i = 0; i < 4; i++) begin
      neg = q_qi[i][COMP_W-1] ^ (inv_mode && (i != 0));
      if (neg) begin
        if (big[i] || (quo[i] > 32'h8000_0000)) begin
          qi_nxt.r[i] = 32'h8000_0000;
          lane_ov[i] = 1'b1;
        end else begin
          qi_nxt.r[i] = ~quo[i] + 1'b1;
        end
      end else begin
        if (big[i] || quo[i][QUO_W-1]) begin
          qi_nxt.r[i] = 32'h7FFF_FFFF;
          lane_ov[i] = 1'b1;
        end else begin
          qi_nxt.r[i] = quo[i];
        end
      end
    end
    qi_nxt.ov = |lane_ov;
    if (q_qi == '0) begin
      qi_nxt.r  = q_qi;
      qi_nxt.ov = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qi_r <= qi_nxt;
    end
  end

  qalu_dly #(.WIDTH($bits(res_t)), .DEPTH(S_OUT - S_QI)) u_dly_qi (
    .clk(clk), .en(en), .d(qi_r), .q(qi_o)
  );

  // second Hamilton product for rotate
  qalu_ham #(.FRAC_BITS(FRAC_BITS)) u_ham2 (
    .clk(clk), .en(en), .a(t_qi.r), .b(qi_r.r), .y(h2)
  );

  // final result select
  always_comb begin
    fin = '0;
    case (opcode_t'(op_o))
      OP_ADD, OP_SUB, OP_CONJUGATE: fin = simple_o;
      OP_SCALE, OP_PRODUCT:         fin = t_o;
      OP_NORM: begin
        // norm above the positive range saturates
        if (root_o[ROOT_W-1:COMP_W-1] != '0) begin
          fin.r[0] = 32'h7FFF_FFFF;
          fin.ov   = 1'b1;
        end else begin
          fin.r[0] = root_o[COMP_W-1:0];
        end
      end
      OP_INVERSE, OP_NORMALIZE:     fin = qi_o;
      OP_ROTATE: begin
        fin.r  = h2.r;
        fin.ov = t_o.ov | qi_o.ov | h2.ov;
      end
      default:                      fin = '0;
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[S_OUT-1:1], in_bus.valid};
    end
  end

  // two entry output buffer
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        ent0_r <= fin;
      end else begin
        ent0_r <= ent1_r;
        ent1_r <= fin;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        ent0_r <= fin;
      end else begin
        ent1_r <= fin;
      end
    end else if (pop) begin
      ent0_r <= ent1_r;
    end
  end

  assign out_bus.valid    = cnt_r != 2'd0;
  assign out_bus.r_w      = ent0_r.r[0];
  assign out_bus.r_x      = ent0_r.r[1];
  assign out_bus.r_y      = ent0_r.r[2];
  assign out_bus.r_z      = ent0_r.r[3];
  assign out_bus.overflow = ent0_r.ov;

  // an accepted beat occupies the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> v_r[1])
    else $error("accepted beat missing from first stage");

  // a stall holds every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (v_r == $past(v_r)))
    else $error("pipeline moved during stall");

  // the buffer is never empty right after a push
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (cnt_r != 2'd0))
    else $error("pushed result lost");

  // results only leave through a handshake
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_bus.valid) |-> $past(pop))
    else $error("result dropped without handshake");

  // buffer count stays within two entries
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overfilled");

endmodule

`default_nettype wire

// ===== sv/qalu_dly.sv =====
// enabled shift register delay line
`timescale 1ns / 1ps
`default_nettype none

module qalu_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // shift one stage per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

`default_nettype wire

// ===== sv/qalu_ham.sv =====
// Hamilton product, four lanes, multiply stage then sum, round and saturate
`timescale 1ns / 1ps
`default_nettype none

module qalu_ham import qalu_pkg::*; #(
  parameter int FRAC_BITS = QALU_FRAC_BITS
) (
  input  logic  clk,
  input  logic  en,
  input  quat_t a,
  input  quat_t b,
  output res_t  y
);

  localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod_r [4][4];
  res_t               y_r;
  res_t               y_nxt;

  // all sixteen products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 4; i++) begin
          prod_r[k][i] <= $signed(a[i]) * $signed(b[HAM_IDX[k][i]]);
        end
      end
    end
  end

  // lane sums, round half up, saturate
  always_comb begin
    logic signed [65:0] acc;
    logic signed [65:0] sh;
    logic [COMP_W:0]    s;
    logic [3:0]         lane_ov;
    y_nxt = '0;
    lane_ov = '0;
    for (int k = 0; k < 4; k++) begin
      acc = '0;
      for (int i = 0; i < 4; i++) begin
        if (HAM_NEG[k][i]) begin
          acc = acc - 66'(prod_r[k][i]);
        end else begin
          acc = acc + 66'(prod_r[k][i]);
        end
      end
      sh = (acc + RND) >>> FRAC_BITS;
      s = sat_s32(sh);
      lane_ov[k] = s[COMP_W];
      y_nxt.r[k] = s[COMP_W-1:0];
    end
    y_nxt.ov = |lane_ov;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

// ===== sv/qalu_sqrt.sv =====
// sum of squares and pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module qalu_sqrt import qalu_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  quat_t              q,
  output logic [SUMSQ_W-1:0] sumsq,
  output logic [ROOT_W-1:0]  root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 4;

  logic [2*COMP_W-1:0]  sq_r [4];
  logic [RAD_W-1:0]     rad_r  [ROOT_W+1];
  logic [REM_W-1:0]     rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]    root_r [ROOT_W+1];
  logic [SUMSQ_W-1:0]   sum_r  [ROOT_W+1];

  // squared magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= mag32(q[i]) * mag32(q[i]);
      end
    end
  end

  // sum of squares seeds the root iterations
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r[0]  <= SUMSQ_W'(sq_r[0]) + SUMSQ_W'(sq_r[1]) + SUMSQ_W'(sq_r[2])
                 + SUMSQ_W'(sq_r[3]);
      rad_r[0]  <= RAD_W'(SUMSQ_W'(sq_r[0]) + SUMSQ_W'(sq_r[1]) + SUMSQ_W'(sq_r[2])
                 + SUMSQ_W'(sq_r[3]));
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // restoring root stages
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W-1:0] remsh;
    logic [REM_W-1:0] trial;

    always_comb begin
      remsh = {rem_r[j][REM_W-3:0], rad_r[j][RAD_W-1 -: 2]};
      trial = {2'b00, root_r[j], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j+1] <= {rad_r[j][RAD_W-3:0], 2'b00};
        sum_r[j+1] <= sum_r[j];
        if (remsh >= trial) begin
          rem_r[j+1]  <= remsh - trial;
          root_r[j+1] <= {root_r[j][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j+1]  <= remsh;
          root_r[j+1] <= {root_r[j][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign sumsq = sum_r[ROOT_W];
  assign root  = root_r[ROOT_W];

endmodule

`default_nettype wire

// ===== sv/qalu_div.sv =====
// pipelined restoring divider lane, 32 quotient bits, flags quotients past 32 bits
`timescale 1ns / 1ps
`default_nettype none

module qalu_div import qalu_pkg::*; #(
  parameter int NUM_W = COMP_W + 2 * QALU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic [NUM_W-1:0]   num,
  input  logic [SUMSQ_W-1:0] den,
  output logic [QUO_W-1:0]   quo,
  output logic               big
);

  localparam int CW = (NUM_W > SUMSQ_W + QUO_W) ? NUM_W : SUMSQ_W + QUO_W;

  logic [SUMSQ_W-1:0] rem_r [QUO_W+1];
  logic [SUMSQ_W-1:0] den_r [QUO_W+1];
  logic [QUO_W-1:0]   low_r [QUO_W+1];
  logic [QUO_W-1:0]   quo_r [QUO_W+1];
  logic               big_r [QUO_W+1];

  // range check and initial partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      big_r[0] <= CW'(num) >= (CW'(den) << QUO_W);
      rem_r[0] <= SUMSQ_W'(CW'(num) >> QUO_W);
      low_r[0] <= num[QUO_W-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [SUMSQ_W:0] remsh;
    logic [SUMSQ_W:0] diff;

    always_comb begin
      remsh = {rem_r[j], low_r[j][QUO_W-1]};
      diff  = remsh - {1'b0, den_r[j]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j+1] <= den_r[j];
        big_r[j+1] <= big_r[j];
        low_r[j+1] <= {low_r[j][QUO_W-2:0], 1'b0};
        if (remsh >= {1'b0, den_r[j]}) begin
          rem_r[j+1] <= diff[SUMSQ_W-1:0];
          quo_r[j+1] <= {quo_r[j][QUO_W-2:0], 1'b1};
        end else begin
          rem_r[j+1] <= remsh[SUMSQ_W-1:0];
          quo_r[j+1] <= {quo_r[j][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[QUO_W];
  assign big = big_r[QUO_W];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench of the quaternion unit: directed, random and backpressure beats
`timescale 1ns / 1ps

module testbench;
  import qalu_pkg::*;

  localparam int FB = QALU_FRAC_BITS;
  localparam int DRAIN_CYCLES = 100;

  typedef longint comp4_t [4];

  typedef struct {
    logic [31:0] w, x, y, z;
    logic        ov;
  } quat_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qalu_in_if  in_bus ();
  qalu_out_if out_bus ();

  quaternion_alu_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #1 clk = ~clk;

  quat_res_t pending_results [$];
  int err_count = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  // ---------------- fixed point predictor ----------------

  function automatic logic [31:0] clamp32(logic signed [127:0] v, ref bit ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint round_fix(logic signed [127:0] acc, ref bit ov);
    logic signed [127:0] t;
    t = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
    return longint'($signed(clamp32(t, ov)));
  endfunction

  // signed magnitude back to 32 bits with saturation
  function automatic longint from_mag(logic [127:0] m, bit neg, ref bit ov);
    if (neg) begin
      if (m <= 128'h8000_0000) return -longint'(m[63:0]);
      ov = 1'b1;
      return -64'sd2147483648;
    end
    if (m <= 128'h7FFF_FFFF) return longint'(m[63:0]);
    ov = 1'b1;
    return 64'sd2147483647;
  endfunction

  function automatic logic [127:0] mag_of(longint v);
    return {64'b0, (v < 0) ? -v : v};
  endfunction

  function automatic logic [127:0] sum_squares(comp4_t a);
    logic [127:0] s;
    s = 0;
    for (int i = 0; i < 4; i++) s += mag_of(a[i]) * mag_of(a[i]);
    return s;
  endfunction

  function automatic logic [63:0] int_root(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] cand;
    r = 0;
    for (int b = 32; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'b0, cand} * {64'b0, cand} <= s) r = cand;
    end
    return r;
  endfunction

  function automatic comp4_t ham_product(comp4_t a, comp4_t b, ref bit ov);
    logic signed [127:0] acc [4];
    comp4_t r;
    acc[0] = 128'(a[0]*b[0]) - 128'(a[1]*b[1]) - 128'(a[2]*b[2]) - 128'(a[3]*b[3]);
    acc[1] = 128'(a[0]*b[1]) + 128'(a[1]*b[0]) + 128'(a[2]*b[3]) - 128'(a[3]*b[2]);
    acc[2] = 128'(a[0]*b[2]) - 128'(a[1]*b[3]) + 128'(a[2]*b[0]) + 128'(a[3]*b[1]);
    acc[3] = 128'(a[0]*b[3]) + 128'(a[1]*b[2]) - 128'(a[2]*b[1]) + 128'(a[3]*b[0]);
    for (int k = 0; k < 4; k++) r[k] = round_fix($signed(acc[k]), ov);
    return r;
  endfunction

  function automatic bit all_zero(comp4_t a);
    return a[0] == 0 && a[1] == 0 && a[2] == 0 && a[3] == 0;
  endfunction

  function automatic comp4_t quat_inverse(comp4_t a, ref bit ov);
    comp4_t r;
    logic [127:0] s;
    if (all_zero(a)) return a;
    s = sum_squares(a);
    for (int i = 0; i < 4; i++) begin
      if (a[i] == 0) r[i] = 0;
      else r[i] = from_mag((mag_of(a[i]) << (2 * FB)) / s, (a[i] < 0) != (i != 0), ov);
    end
    return r;
  endfunction

  function automatic comp4_t quat_normalize(comp4_t a, ref bit ov);
    comp4_t r;
    logic [127:0] n;
    if (all_zero(a)) return a;
    n = {64'b0, int_root(sum_squares(a))};
    for (int i = 0; i < 4; i++) r[i] = from_mag((mag_of(a[i]) << FB) / n, a[i] < 0, ov);
    return r;
  endfunction

  function automatic quat_res_t predict_result(logic [3:0] op, logic [31:0] qv [4],
                                               logic [31:0] pv [4], logic [31:0] m);
    comp4_t q, p, r, t, qi;
    bit ov;
    logic [63:0] n;
    quat_res_t res;
    ov = 1'b0;
    for (int i = 0; i < 4; i++) begin
      q[i] = longint'($signed(qv[i]));
      p[i] = longint'($signed(pv[i]));
      r[i] = 0;
    end
    case (op)
      OP_ADD:
        for (int i = 0; i < 4; i++) r[i] = longint'($signed(clamp32(128'(q[i] + p[i]), ov)));
      OP_SUB:
        for (int i = 0; i < 4; i++) r[i] = longint'($signed(clamp32(128'(q[i] - p[i]), ov)));
      OP_SCALE:
        for (int i = 0; i < 4; i++)
          r[i] = round_fix(128'(q[i] * longint'($signed(m))), ov);
      OP_PRODUCT: r = ham_product(q, p, ov);
      OP_CONJUGATE: begin
        r[0] = q[0];
        for (int i = 1; i < 4; i++) r[i] = longint'($signed(clamp32(128'(-q[i]), ov)));
      end
      OP_NORM: begin
        n = int_root(sum_squares(q));
        if (n > 64'h7FFF_FFFF) begin
          ov = 1'b1;
          n = 64'h7FFF_FFFF;
        end
        r[0] = longint'(n);
      end
      OP_INVERSE: r = quat_inverse(q, ov);
      OP_NORMALIZE: r = quat_normalize(q, ov);
      OP_ROTATE: begin
        t  = ham_product(q, p, ov);
        qi = quat_inverse(q, ov);
        r  = ham_product(t, qi, ov);
      end
      default: ;
    endcase
    res.w = r[0][31:0];
    res.x = r[1][31:0];
    res.y = r[2][31:0];
    res.z = r[3][31:0];
    res.ov = ov;
    return res;
  endfunction

  // ---------------- input side ----------------

  initial begin
    in_bus.valid = 1'b0;
    in_bus.opcode = '0;
    {in_bus.q_w, in_bus.q_x, in_bus.q_y, in_bus.q_z} = '0;
    {in_bus.p_w, in_bus.p_x, in_bus.p_y, in_bus.p_z} = '0;
    in_bus.scale = '0;
    out_bus.ready = 1'b0;
  end

  // send one beat, with an optional idle burst in front of it
  task automatic send_item(logic [3:0] op, logic [31:0] qv [4], logic [31:0] pv [4],
                           logic [31:0] m);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.opcode <= op;
    in_bus.q_w <= qv[0]; in_bus.q_x <= qv[1]; in_bus.q_y <= qv[2]; in_bus.q_z <= qv[3];
    in_bus.p_w <= pv[0]; in_bus.p_x <= pv[1]; in_bus.p_y <= pv[2]; in_bus.p_z <= pv[3];
    in_bus.scale <= m;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(predict_result(op, qv, pv, m));
  endtask

  // mostly modest Q16.16 values, some full range, some extremes
  function automatic logic [31:0] rand_comp();
    logic [31:0] corner [8] = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h0000_8000};
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return corner[$urandom_range(0, 7)];
      3:       return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic send_random(logic [3:0] op);
    logic [31:0] qv [4];
    logic [31:0] pv [4];
    for (int i = 0; i < 4; i++) begin
      qv[i] = rand_comp();
      pv[i] = rand_comp();
    end
    // zero first quaternion now and then, for every opcode
    if ($urandom_range(0, 15) == 0) qv = '{default: 32'h0};
    send_item(op, qv, pv, rand_comp());
  endtask

  // ---------------- result side ----------------

  // receiver ready: long hold when asked, else random stall bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (burst > 0) begin
        out_bus.ready <= 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        burst = $urandom_range(0, 15);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    quat_res_t exp_res;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_bus.r_w !== exp_res.w) begin
          $error("r_w expected %h actual %h", exp_res.w, out_bus.r_w);
          err_count++;
        end
        if (out_bus.r_x !== exp_res.x) begin
          $error("r_x expected %h actual %h", exp_res.x, out_bus.r_x);
          err_count++;
        end
        if (out_bus.r_y !== exp_res.y) begin
          $error("r_y expected %h actual %h", exp_res.y, out_bus.r_y);
          err_count++;
        end
        if (out_bus.r_z !== exp_res.z) begin
          $error("r_z expected %h actual %h", exp_res.z, out_bus.r_z);
          err_count++;
        end
        if (out_bus.overflow !== exp_res.ov) begin
          $error("overflow expected %b actual %b", exp_res.ov, out_bus.overflow);
          err_count++;
        end
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    logic [31:0] one [4]  = '{32'h0001_0000, 32'h0, 32'h0, 32'h0};
    logic [31:0] zero [4] = '{default: 32'h0};
    logic [31:0] maxq [4] = '{default: 32'h7FFF_FFFF};
    logic [31:0] minq [4] = '{default: 32'h8000_0000};
    logic [31:0] mixq [4] = '{32'h0002_0000, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_FFFF};
    logic [31:0] vec [4]  = '{32'h0, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000};
    // every operation on a plain quaternion
    for (int op = OP_ADD; op <= OP_ROTATE; op++) send_item(4'(op), mixq, vec, 32'h0001_8000);
    // saturation at both ends
    send_item(OP_ADD, maxq, maxq, 32'h0);
    send_item(OP_SUB, minq, maxq, 32'h0);
    send_item(OP_SCALE, maxq, zero, 32'h8000_0000);
    send_item(OP_PRODUCT, minq, minq, 32'h0);
    send_item(OP_NORM, minq, zero, 32'h0);
    send_item(OP_INVERSE, '{32'h1, 32'h0, 32'h0, 32'h0}, zero, 32'h0);
    // conjugate of the most negative value
    send_item(OP_CONJUGATE, minq, zero, 32'h0);
    // zero quaternion through inverse, normalize and rotate
    send_item(OP_INVERSE, zero, vec, 32'h0);
    send_item(OP_NORMALIZE, zero, vec, 32'h0);
    send_item(OP_ROTATE, zero, vec, 32'h0);
    // identity rotation and unused opcodes
    send_item(OP_ROTATE, one, vec, 32'h0);
    send_item(4'd9, maxq, maxq, 32'hFFFF_FFFF);
    send_item(4'd15, minq, maxq, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) send_random(4'($urandom_range(9, 15)));
      else send_random(4'($urandom_range(OP_ADD, OP_ROTATE)));
    end
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills and stalls
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles = 300;
    test_random(150);
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random(200);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(850);
    test_backpressure();
    test_no_idle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
